@@ hdl/rsti_pkg.sv @@
// Package for the radix string-to-integer core: types, constants and character classes.
package rsti_pkg;

    localparam int MAX_BASE   = 16;
    localparam int SLOT_W     = $clog2(MAX_BASE);
    localparam int BASE_LEN_W = $clog2(MAX_BASE + 1);
    localparam int CHAR_W     = 8;
    localparam int VALUE_W    = 32;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_FEED  = 1'b1;

    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FIN
    } state_t;

    typedef enum logic [1:0] {
        PH_SPACE,
        PH_SIGN,
        PH_DIGIT,
        PH_STOP
    } phase_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic op;
        logic last;
        logic out_busy;
    } sts_t;

    function automatic logic is_space(input logic [CHAR_W-1:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_sign(input logic [CHAR_W-1:0] c);
        return (c == CH_PLUS) || (c == CH_MINUS);
    endfunction

endpackage

@@ hdl/rsti_ctrl.sv @@
// Controller state machine: sequences load, execute and result steps.
module rsti_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  rsti_pkg::sts_t sts,
    output rsti_pkg::cmd_t cmd
);
    import rsti_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
                if ((sts.op == OP_FEED) && sts.last)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_FIN:
            begin
                if (!sts.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ hdl/rsti_dp.sv @@
// Datapath: alphabet registers, digit match, accumulator, validity check and result register.
module rsti_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [rsti_pkg::BASE_LEN_W-1:0]     cfg_wr_data,
    input  logic                                op,
    input  logic [rsti_pkg::SLOT_W-1:0]         slot,
    input  logic [rsti_pkg::CHAR_W-1:0]         ch,
    input  logic                                last,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [rsti_pkg::VALUE_W-1:0] value,
    output logic                                base_valid,
    input  rsti_pkg::cmd_t                      cmd,
    output rsti_pkg::sts_t                      sts
);
    import rsti_pkg::*;

    logic [BASE_LEN_W-1:0] base_len_reg;
    logic [CHAR_W-1:0]     alphabet_reg [MAX_BASE];

    logic                  op_reg;
    logic [SLOT_W-1:0]     slot_reg;
    logic [CHAR_W-1:0]     ch_reg;
    logic                  last_reg;

    phase_t                phase_reg;
    phase_t                phase_next;
    logic                  neg_reg;
    logic                  neg_next;
    logic [VALUE_W-1:0]    acc_reg;
    logic [VALUE_W-1:0]    acc_next;

    logic                  out_valid_reg;
    logic [VALUE_W-1:0]    value_reg;
    logic                  base_valid_reg;

    logic                  hit;
    logic [SLOT_W-1:0]     digit;
    logic                  alpha_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_len_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            base_len_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= op;
            slot_reg <= slot;
            ch_reg   <= ch;
            last_reg <= last;
        end
        if (cmd.exec && (op_reg == OP_WRITE))
        begin
            alphabet_reg[slot_reg] <= ch_reg;
        end
    end

    // lowest matching used slot wins
    always_comb
    begin
        hit   = 1'b0;
        digit = '0;
        for (int k = MAX_BASE - 1; k >= 0; k--)
        begin
            if ((BASE_LEN_W'(k) < base_len_reg) && (alphabet_reg[k] == ch_reg))
            begin
                hit   = 1'b1;
                digit = SLOT_W'(k);
            end
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        neg_next   = neg_reg;
        acc_next   = acc_reg;
        if (phase_next == PH_SPACE && !is_space(ch_reg))
        begin
            phase_next = PH_SIGN;
        end
        if (phase_next == PH_SIGN)
        begin
            if (is_sign(ch_reg))
            begin
                if (ch_reg == CH_MINUS)
                begin
                    neg_next = !neg_reg;
                end
            end
            else
            begin
                phase_next = PH_DIGIT;
            end
        end
        if (phase_next == PH_DIGIT)
        begin
            if (hit)
            begin
                acc_next = acc_reg * VALUE_W'(base_len_reg) + VALUE_W'(digit);
            end
            else
            begin
                phase_next = PH_STOP;
            end
        end
    end

    always_comb
    begin
        alpha_ok = (base_len_reg >= BASE_LEN_W'(2))
                && (base_len_reg <= BASE_LEN_W'(MAX_BASE));
        for (int i = 0; i < MAX_BASE; i++)
        begin
            if (BASE_LEN_W'(i) < base_len_reg)
            begin
                if ((alphabet_reg[i] == CH_NUL) || is_space(alphabet_reg[i])
                    || is_sign(alphabet_reg[i]))
                begin
                    alpha_ok = 1'b0;
                end
                for (int j = 0; j < i; j++)
                begin
                    if (alphabet_reg[j] == alphabet_reg[i])
                    begin
                        alpha_ok = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SPACE;
            neg_reg   <= 1'b0;
            acc_reg   <= '0;
        end
        else if (cmd.finish)
        begin
            phase_reg <= PH_SPACE;
            neg_reg   <= 1'b0;
            acc_reg   <= '0;
        end
        else if (cmd.exec && (op_reg == OP_FEED))
        begin
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            acc_reg   <= acc_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            base_valid_reg <= alpha_ok;
            if (!alpha_ok)
            begin
                value_reg <= '0;
            end
            else if (neg_reg)
            begin
                value_reg <= '0 - acc_reg;
            end
            else
            begin
                value_reg <= acc_reg;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign value        = value_reg;
    assign base_valid   = base_valid_reg;
    assign sts.op       = op_reg;
    assign sts.last     = last_reg;
    assign sts.out_busy = out_valid_reg && !out_ready;

endmodule

@@ hdl/radix_string_to_integer_core.sv @@
// Top level of the radix string-to-integer core: controller plus datapath.
//
//  channel | handshake              | payload
//  --------+------------------------+-------------------------
//  in      | in_valid / in_ready    | op, slot, ch, last
//  out     | out_valid / out_ready  | value, base_valid
//  cfg     | cfg_wr_en              | cfg_wr_data (base_len)
//
// Each input transfer is loaded, then executed with the 16-way
// symbol match and a 32x5 multiply-add; a last character adds a finish
// step that checks the alphabet and loads the output register.
// The output register lets input continue while a result waits; only a
// second result blocks, in the finish step, until out_ready.
// Reset clears base_len and the parse state; the alphabet is not cleared.
module radix_string_to_integer_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [rsti_pkg::BASE_LEN_W-1:0]     cfg_wr_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                op,
    input  logic [rsti_pkg::SLOT_W-1:0]         slot,
    input  logic [rsti_pkg::CHAR_W-1:0]         ch,
    input  logic                                last,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [rsti_pkg::VALUE_W-1:0] value,
    output logic                                base_valid
);
    import rsti_pkg::*;

    cmd_t cmd;
    sts_t sts;

    rsti_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rsti_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .op          (op),
        .slot        (slot),
        .ch          (ch),
        .last        (last),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .value       (value),
        .base_valid  (base_valid),
        .cmd         (cmd),
        .sts         (sts)
    );

endmodule

@@ hdl/rsti_chk.sv @@
// Port-level assertion checker for the radix string-to-integer core, with its bind.
module rsti_chk (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic signed [rsti_pkg::VALUE_W-1:0] value,
    input logic                                base_valid
);
    import rsti_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(value) && $stable(base_valid))
        else $error("output changed while stalled");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !base_valid |-> value == '0)
        else $error("invalid alphabet result is not zero");

    a_two_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("transfer accepted in back-to-back cycles");

    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid |=> !out_valid)
        else $error("result appeared one cycle after transfer");

endmodule

bind radix_string_to_integer_core rsti_chk u_rsti_chk (.*);

@@ bench/radix_string_to_integer_core_tb.sv @@
// Testbench for radix_string_to_integer_core: scoreboard prediction under random handshakes.
module radix_string_to_integer_core_tb;
    import rsti_pkg::*;

    localparam int SETTLE      = 8;
    localparam int HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASES      = 14;
    localparam int HOLD_PHASE  = 2;
    localparam logic [BASE_LEN_W-1:0] RADIX_PLAN [7] = '{5'd2, 5'd16, 5'd10, 5'd0, 5'd31,
                                                         5'd17, 5'd1};

    typedef enum int {
        FLAW_NONE,
        FLAW_BLANK,
        FLAW_SIGN,
        FLAW_NUL,
        FLAW_DUP
    } flaw_t;

    typedef struct {
        logic signed [VALUE_W-1:0] value;
        logic                      base_valid;
    } parse_result_t;

    class atoi_scoreboard;
        logic [CHAR_W-1:0]     symbols [MAX_BASE];
        logic [BASE_LEN_W-1:0] radix;
        phase_t                phase;
        bit                    negative;
        logic [VALUE_W-1:0]    acc;
        parse_result_t         pending_q [$];
        int                    errors;
        int                    checked;
        int                    rejected;

        function new();
            foreach (symbols[i])
                symbols[i] = '0;
            radix    = '0;
            errors   = 0;
            checked  = 0;
            rejected = 0;
            clear_parse();
        endfunction

        function void clear_parse();
            phase    = PH_SPACE;
            negative = 1'b0;
            acc      = '0;
        endfunction

        task report(input string msg);
            errors++;
            if (errors <= 40)
                $display("ERROR @%0t: %s", $time, msg);
        endtask

        function bit is_blank(input logic [CHAR_W-1:0] c);
            return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
        endfunction

        function bit is_sign_char(input logic [CHAR_W-1:0] c);
            return (c == CH_PLUS) || (c == CH_MINUS);
        endfunction

        function bit alphabet_ok();
            if (radix < 2 || radix > MAX_BASE)
                return 1'b0;
            for (int i = 0; i < radix; i++)
            begin
                if (symbols[i] == CH_NUL || is_blank(symbols[i]) || is_sign_char(symbols[i]))
                    return 1'b0;
                for (int j = 0; j < i; j++)
                    if (symbols[j] == symbols[i])
                        return 1'b0;
            end
            return 1'b1;
        endfunction

        function int digit_of(input logic [CHAR_W-1:0] c);
            int n;
            n = (radix > MAX_BASE) ? MAX_BASE : int'(radix);
            for (int k = 0; k < n; k++)
                if (symbols[k] == c)
                    return k;
            return -1;
        endfunction

        function void note_input(input logic op_i, input logic [SLOT_W-1:0] slot_i,
                                 input logic [CHAR_W-1:0] ch_i, input logic last_i);
            int            d;
            parse_result_t r;
            if (op_i == OP_WRITE)
            begin
                symbols[slot_i] = ch_i;
                return;
            end
            if (phase == PH_SPACE && !is_blank(ch_i))
                phase = PH_SIGN;
            if (phase == PH_SIGN)
            begin
                if (is_sign_char(ch_i))
                begin
                    if (ch_i == CH_MINUS)
                        negative = !negative;
                end
                else
                    phase = PH_DIGIT;
            end
            if (phase == PH_DIGIT)
            begin
                d = digit_of(ch_i);
                if (d < 0)
                    phase = PH_STOP;
                else
                    acc = acc * VALUE_W'(radix) + VALUE_W'(d);
            end
            if (!last_i)
                return;
            if (alphabet_ok())
            begin
                r.value      = negative ? -acc : acc;
                r.base_valid = 1'b1;
            end
            else
            begin
                r.value      = '0;
                r.base_valid = 1'b0;
                rejected++;
            end
            pending_q.push_back(r);
            clear_parse();
        endfunction

        task check_result(input logic signed [VALUE_W-1:0] v, input logic bv);
            parse_result_t e;
            if (pending_q.size() == 0)
            begin
                report($sformatf("unexpected result value=%0d base_valid=%0b", v, bv));
                return;
            end
            e = pending_q.pop_front();
            checked++;
            if (v !== e.value)
                report($sformatf("value %0d, expected %0d", v, e.value));
            if (bv !== e.base_valid)
                report($sformatf("base_valid %0b, expected %0b", bv, e.base_valid));
        endtask
    endclass

    logic                      clk         = 1'b0;
    logic                      rst_n       = 1'b0;
    logic                      cfg_wr_en   = 1'b0;
    logic [BASE_LEN_W-1:0]     cfg_wr_data = '0;
    logic                      in_valid    = 1'b0;
    logic                      in_ready;
    logic                      op          = OP_WRITE;
    logic [SLOT_W-1:0]         slot        = '0;
    logic [CHAR_W-1:0]         ch          = '0;
    logic                      last        = 1'b0;
    logic                      out_valid;
    logic                      out_ready   = 1'b0;
    logic signed [VALUE_W-1:0] value;
    logic                      base_valid;

    atoi_scoreboard sb = new();

    int burst_left = 0;
    int items_sent = 0;
    bit hold_req   = 1'b0;
    bit hold_done  = 1'b0;
    int hold_left  = 0;
    int rx_tick    = 0;
    int cycles     = 0;

    radix_string_to_integer_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .slot        (slot),
        .ch          (ch),
        .last        (last),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .value       (value),
        .base_valid  (base_valid)
    );

    always #1 clk = ~clk;

    task automatic send_item(input logic o, input logic [SLOT_W-1:0] s,
                             input logic [CHAR_W-1:0] c, input logic l);
        int gap;
        in_valid <= 1'b1;
        op       <= o;
        slot     <= s;
        ch       <= c;
        last     <= l;
        do @(posedge clk); while (!in_ready);
        sb.note_input(o, s, c, l);
        items_sent++;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            gap        = $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 12);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_radix(input logic [BASE_LEN_W-1:0] r);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= r;
        @(posedge clk);
        sb.radix = r;
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [CHAR_W-1:0] blank_char();
        int k;
        k = $urandom_range(0, 5);
        return (k == 5) ? CH_SPACE : CH_TAB + CHAR_W'(k);
    endfunction

    task automatic load_alphabet(input flaw_t flaw);
        logic [CHAR_W-1:0] pick [MAX_BASE];
        bit                taken [256];
        logic [CHAR_W-1:0] c;
        int                used;
        int                victim;
        int                start;
        foreach (taken[i])
            taken[i] = 1'b0;
        for (int i = 0; i < MAX_BASE; i++)
        begin
            do c = CHAR_W'($urandom_range(1, 255));
            while (taken[c] || c == CH_PLUS || c == CH_MINUS || c == CH_SPACE ||
                   (c >= CH_TAB && c <= CH_CR));
            taken[c] = 1'b1;
            pick[i]  = c;
        end
        used = (sb.radix > MAX_BASE) ? MAX_BASE : int'(sb.radix);
        if (used >= 2 && flaw != FLAW_NONE)
        begin
            victim = $urandom_range(1, used - 1);
            case (flaw)
                FLAW_BLANK: pick[victim] = blank_char();
                FLAW_SIGN:  pick[victim] = $urandom_range(0, 1) ? CH_MINUS : CH_PLUS;
                FLAW_NUL:   pick[victim] = CH_NUL;
                default:    pick[victim] = pick[$urandom_range(0, victim - 1)];
            endcase
        end
        start = $urandom_range(0, MAX_BASE - 1);
        for (int i = 0; i < MAX_BASE; i++)
            send_item(OP_WRITE, SLOT_W'((start + i) % MAX_BASE), pick[(start + i) % MAX_BASE],
                      1'($urandom_range(0, 1)));
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_item(OP_FEED, SLOT_W'($urandom), s[i], i == s.len() - 1);
    endtask

    task automatic send_string(input bit noise);
        logic [CHAR_W-1:0] text [$];
        int                n_sym;
        n_sym = (sb.radix > MAX_BASE) ? MAX_BASE : int'(sb.radix);
        if (noise)
        begin
            repeat ($urandom_range(1, 6))
                text.push_back(CHAR_W'($urandom_range(0, 255)));
        end
        else
        begin
            repeat ($urandom_range(0, 3))
                text.push_back(blank_char());
            repeat ($urandom_range(0, 3))
                text.push_back($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
            if (n_sym > 0)
                repeat ($urandom_range(0, 10))
                    text.push_back(sb.symbols[$urandom_range(0, n_sym - 1)]);
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3))
                    text.push_back(($urandom_range(0, 3) == 0) ? CH_NUL
                                                               : CHAR_W'($urandom_range(0, 255)));
            if (text.size() == 0)
                text.push_back(CHAR_W'($urandom_range(0, 255)));
        end
        foreach (text[i])
        begin
            // occasional alphabet rewrite in the middle of a string
            if ($urandom_range(0, 49) == 0)
                send_item(OP_WRITE, SLOT_W'($urandom), CHAR_W'($urandom), 1'($urandom_range(0, 1)));
            send_item(OP_FEED, SLOT_W'($urandom), text[i], i == text.size() - 1);
        end
    endtask

    always @(posedge clk)
    begin
        if (out_valid && out_ready)
            sb.check_result(value, base_valid);
        rx_tick++;
        if (hold_req && !hold_done)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            case ((rx_tick / 32) % 4)
                0:       out_ready <= 1'b1;
                1:       out_ready <= 1'($urandom_range(0, 1));
                2:       out_ready <= ($urandom_range(0, 4) != 0);
                default: out_ready <= ((rx_tick % 32) >= 12);
            endcase
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        string                 hex;
        int                    mark;
        int                    goal;
        logic [BASE_LEN_W-1:0] r;
        flaw_t                 flaw;
        hex = "0123456789ABCDEF";
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int k = 0; k < MAX_BASE; k++)
            send_item(OP_WRITE, SLOT_W'(k), hex[k], k[0]);
        set_radix(5'd16);
        send_text(" \t-+-Fz9");
        send_text("FFFFFFFFF");
        set_radix(5'd0);
        send_text("7");
        set_radix(5'd31);
        send_text("-1");
        set_radix(5'd1);
        send_text("0");

        for (int p = 0; p < PHASES; p++)
        begin
            r = (p < 7) ? RADIX_PLAN[p] : BASE_LEN_W'($urandom_range(2, MAX_BASE));
            set_radix(r);
            flaw = (p >= PHASES - 4) ? flaw_t'(p - (PHASES - 5)) : FLAW_NONE;
            load_alphabet(flaw);
            if (p == HOLD_PHASE)
                hold_req <= 1'b1;
            goal = (r < 2 || r > MAX_BASE || flaw != FLAW_NONE) ? 15 : 45;
            mark = items_sent;
            while (items_sent - mark < goal)
                send_string($urandom_range(0, 9) == 0);
        end

        drain();
        repeat (20) @(posedge clk);
        if (sb.pending_q.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending_q.size()));
        $display("Run covered %0d input transfers and %0d parsed strings (%0d rejected alphabets).",
                 items_sent, sb.checked, sb.rejected);
        $display("Radix settings 0 to 31, flawed alphabets, and a %0d-cycle output hold-off.",
                 HOLD_CYCLES);
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
